// ----- rtl/pfbe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfbe_pkg: shared types and constants of the postfix boolean evaluator
// Sizes of the node store, action, status and node kind codes, the node
// record kept in memory, and the sequencer states.
// ----------------------------------------------------------------------------
package pfbe_pkg;

	// node store and work stack depth
	localparam int NODE_SLOTS = 32;
	// bits of a node index, and of a count that can reach NODE_SLOTS
	localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int CNT_W = $clog2(NODE_SLOTS + 1);
	// most items one explain may report
	localparam int OUT_LIMIT = 32;
	// fixed field widths
	localparam int POS_W = 7;
	localparam int REL_W = 16;

	typedef enum logic [1:0] {
		ACT_LEAF    = 2'd0,
		ACT_AND     = 2'd1,
		ACT_OR      = 2'd2,
		ACT_EXPLAIN = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_LEAF = 2'd0,
		KIND_AND  = 2'd1,
		KIND_OR   = 2'd2
	} node_kind_t;

	// one stored node: r1 holds the relation id of a leaf or the first
	// deciding operand, r2 the second deciding operand
	typedef struct packed {
		node_kind_t       kind;
		logic             truth;
		logic [REL_W-1:0] r1;
		logic [IDX_W-1:0] r2;
		logic [1:0]       cnt;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_LEAF,
		S_RD_NEW,
		S_RD_OLD,
		S_RD_TRUTH,
		S_COMB,
		S_EX_START,
		S_EX_QRD,
		S_EX_NRD,
		S_EX_CH0,
		S_EX_CH1,
		S_EX_EMIT
	} state_t;

endpackage

// ----- rtl/pfbe_ram.sv -----
// ----------------------------------------------------------------------------
// pfbe_ram: simple dual port memory
// One write port and one read port; read data is registered and holds
// while no read is issued. Contents are undefined until written.
// ----------------------------------------------------------------------------
module pfbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/postfix_boolean_evaluator_with_reasons_core.sv -----
// ----------------------------------------------------------------------------
// postfix_boolean_evaluator_with_reasons_core: postfix boolean evaluator
// Builds a node store from a postfix stream of leaves, ANDs and ORs, keeps the
// deciding operands of every node and explains the newest node as a breadth
// first reason tree.
// Input channel (in_valid/in_ready): action, leaf_truth, relation_id. Output
// channel (out_valid/out_ready): result items, last set on the final one of
// each input. A leaf, AND or OR gives one item with the new node index; an
// explain gives one item per tree node, at most 32, breadth first; an error
// (underflow, full store, empty explain) gives one item and changes nothing.
// Steps, one read port per memory shared by every step:
//   leaf or error: an emit step, which for a leaf also writes the store
//   AND / OR: two stack reads, two node reads, write
//   explain: a setup step, then per node a queue read, a node read, two
//   child slots and an emit
// in_ready is high only while the sequencer is idle. A finished item may wait
// in the output register while the next is accepted; a stalled receiver holds
// the sequencer in its emit step. Reset empties node store and stack (counts
// go to zero) and drops a pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module postfix_boolean_evaluator_with_reasons_core
	import pfbe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic             leaf_truth,
	input  logic [REL_W-1:0] relation_id,
	// output channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [1:0]       node_kind,
	output logic             node_truth,
	output logic [POS_W-1:0] position,
	output logic [REL_W-1:0] reason_first,
	output logic [REL_W-1:0] reason_second,
	output logic [1:0]       reason_count,
	output logic             last
);

	// ------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------
	state_t           state_q, state_d;
	logic [CNT_W-1:0] node_count_q, node_count_d;
	logic [CNT_W-1:0] depth_q, depth_d;
	logic [CNT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] tail_q, tail_d;

	// accepted item and scratch registers (payload, no reset)
	action_t          act_q;
	logic             leaf_truth_q;
	logic [REL_W-1:0] rel_q;
	status_t          err_q;
	logic [IDX_W-1:0] newer_q;
	logic [IDX_W-1:0] older_q;
	logic             tn_q;
	node_t            ent_q;
	logic [CNT_W-1:0] rs0_q, rs0_d;
	logic [CNT_W-1:0] rs1_q, rs1_d;

	// output register
	logic             out_valid_q;
	status_t          status_q;
	logic [1:0]       kind_q;
	logic             truth_q;
	logic [POS_W-1:0] pos_q;
	logic [REL_W-1:0] rf_q;
	logic [REL_W-1:0] rs_q;
	logic [1:0]       rcnt_q;
	logic             last_q;

	// ------------------------------------------------------------------
	// memories: node store, work stack, explain queue
	// ------------------------------------------------------------------
	logic             nd_we, nd_re;
	logic [IDX_W-1:0] nd_waddr, nd_raddr;
	node_t            nd_wdata, nd_rnode;
	logic [NODE_W-1:0] nd_rdata;

	logic             st_we, st_re;
	logic [IDX_W-1:0] st_waddr, st_raddr, st_wdata, st_rdata;

	logic             q_we, q_re;
	logic [IDX_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

	pfbe_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_node_ram (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.re    (nd_re),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	pfbe_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	pfbe_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	assign nd_rnode = nd_rdata;

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	logic             accept;
	logic             out_free;
	status_t          in_err;
	logic [CNT_W-1:0] dm1, dm2, cm1;
	logic [POS_W-1:0] head_pos;
	logic             ex_last;

	// combine unit
	logic             to_truth;
	logic             res;
	logic             sel_o, sel_n, swap;
	node_t            comb_node;
	node_t            leaf_node;

	// child slots of the node being explained
	logic             ch0_take, ch1_take;

	// output load
	logic             load_out;
	status_t          o_status;
	logic [1:0]       o_kind;
	logic             o_truth;
	logic [POS_W-1:0] o_pos;
	logic [REL_W-1:0] o_rf;
	logic [REL_W-1:0] o_rs;
	logic [1:0]       o_rcnt;
	logic             o_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign dm1      = depth_q - CNT_W'(1);
	assign dm2      = depth_q - CNT_W'(2);
	assign cm1      = node_count_q - CNT_W'(1);
	assign head_pos = POS_W'(head_q) + POS_W'(1);
	// final explain item: queue drained or item limit reached
	assign ex_last  = (head_pos == POS_W'(tail_q)) || (head_pos == POS_W'(OUT_LIMIT));

	// classify an incoming item; underflow wins over a full store
	always_comb begin
		in_err = ST_OK;
		if (action_t'(action) == ACT_EXPLAIN) begin
			if (node_count_q == '0) begin
				in_err = ST_EMPTY;
			end
		end else if (action_t'(action) != ACT_LEAF && depth_q < CNT_W'(2)) begin
			in_err = ST_UNDERFLOW;
		end else if (node_count_q == CNT_W'(NODE_SLOTS)) begin
			in_err = ST_FULL;
		end
	end

	// leaf record
	always_comb begin
		leaf_node       = '0;
		leaf_node.kind  = KIND_LEAF;
		leaf_node.truth = leaf_truth_q;
		leaf_node.r1    = rel_q;
		leaf_node.cnt   = 2'd1;
	end

	// AND / OR: the deciding operands are those whose truth equals the
	// result; a false OR lists the newer operand first
	always_comb begin
		to_truth = nd_rnode.truth;
		res      = (act_q == ACT_AND) ? (tn_q & to_truth) : (tn_q | to_truth);
		sel_o    = (to_truth == res);
		sel_n    = (tn_q == res);
		swap     = (act_q == ACT_OR) && !res;

		comb_node       = '0;
		comb_node.kind  = (act_q == ACT_AND) ? KIND_AND : KIND_OR;
		comb_node.truth = res;
		if (sel_o && sel_n) begin
			comb_node.r1  = swap ? REL_W'(newer_q) : REL_W'(older_q);
			comb_node.r2  = swap ? older_q : newer_q;
			comb_node.cnt = 2'd2;
		end else if (sel_o) begin
			comb_node.r1  = REL_W'(older_q);
			comb_node.cnt = 2'd1;
		end else begin
			comb_node.r1  = REL_W'(newer_q);
			comb_node.cnt = 2'd1;
		end
	end

	// queue a child only while the queue has room and the index is stored
	assign ch0_take = (nd_rnode.kind != KIND_LEAF) && (nd_rnode.cnt != 2'd0)
		&& (tail_q < CNT_W'(NODE_SLOTS)) && (nd_rnode.r1 < REL_W'(node_count_q));
	assign ch1_take = (ent_q.kind != KIND_LEAF) && (ent_q.cnt == 2'd2)
		&& (tail_q < CNT_W'(NODE_SLOTS)) && (REL_W'(ent_q.r2) < REL_W'(node_count_q));

	// ------------------------------------------------------------------
	// sequencer: next state, memory control, output load
	// ------------------------------------------------------------------
	always_comb begin
		state_d      = state_q;
		node_count_d = node_count_q;
		depth_d      = depth_q;
		head_d       = head_q;
		tail_d       = tail_q;
		rs0_d        = rs0_q;
		rs1_d        = rs1_q;

		nd_we    = 1'b0;
		nd_waddr = node_count_q[IDX_W-1:0];
		nd_wdata = leaf_node;
		nd_re    = 1'b0;
		nd_raddr = st_rdata;

		st_we    = 1'b0;
		st_waddr = depth_q[IDX_W-1:0];
		st_wdata = node_count_q[IDX_W-1:0];
		st_re    = 1'b0;
		st_raddr = dm1[IDX_W-1:0];

		q_we     = 1'b0;
		q_waddr  = tail_q[IDX_W-1:0];
		q_wdata  = nd_rnode.r1[IDX_W-1:0];
		q_re     = 1'b0;
		q_raddr  = head_q[IDX_W-1:0];

		load_out = 1'b0;
		o_status = ST_OK;
		o_kind   = KIND_LEAF;
		o_truth  = 1'b0;
		o_pos    = '0;
		o_rf     = '0;
		o_rs     = '0;
		o_rcnt   = '0;
		o_last   = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_err != ST_OK) begin
						state_d = S_ERR;
					end else begin
						case (action_t'(action))
							ACT_LEAF:    state_d = S_LEAF;
							ACT_AND:     state_d = S_RD_NEW;
							ACT_OR:      state_d = S_RD_NEW;
							ACT_EXPLAIN: state_d = S_EX_START;
							default:     state_d = S_IDLE;
						endcase
					end
				end
			end
			S_ERR: begin
				if (out_free) begin
					load_out = 1'b1;
					o_status = err_q;
					state_d  = S_IDLE;
				end
			end
			S_LEAF: begin
				if (out_free) begin
					nd_we        = 1'b1;
					st_we        = 1'b1;
					depth_d      = depth_q + CNT_W'(1);
					node_count_d = node_count_q + CNT_W'(1);
					load_out     = 1'b1;
					o_kind       = KIND_LEAF;
					o_truth      = leaf_truth_q;
					o_pos        = POS_W'(node_count_q);
					o_rf         = rel_q;
					o_rcnt       = 2'd1;
					state_d      = S_IDLE;
				end
			end
			S_RD_NEW: begin
				st_re    = 1'b1;
				st_raddr = dm1[IDX_W-1:0];
				state_d  = S_RD_OLD;
			end
			S_RD_OLD: begin
				// stack data is the newer index: fetch its node
				st_re    = 1'b1;
				st_raddr = dm2[IDX_W-1:0];
				nd_re    = 1'b1;
				nd_raddr = st_rdata;
				state_d  = S_RD_TRUTH;
			end
			S_RD_TRUTH: begin
				// stack data is the older index: fetch its node
				nd_re    = 1'b1;
				nd_raddr = st_rdata;
				state_d  = S_COMB;
			end
			S_COMB: begin
				if (out_free) begin
					nd_we        = 1'b1;
					nd_wdata     = comb_node;
					st_we        = 1'b1;
					st_waddr     = dm2[IDX_W-1:0];
					depth_d      = dm1;
					node_count_d = node_count_q + CNT_W'(1);
					load_out     = 1'b1;
					o_kind       = comb_node.kind;
					o_truth      = comb_node.truth;
					o_pos        = POS_W'(node_count_q);
					o_rf         = comb_node.r1;
					o_rs         = REL_W'(comb_node.r2);
					o_rcnt       = comb_node.cnt;
					state_d      = S_IDLE;
				end
			end
			S_EX_START: begin
				// seed the queue with the newest node
				q_we    = 1'b1;
				q_waddr = '0;
				q_wdata = cm1[IDX_W-1:0];
				head_d  = '0;
				tail_d  = CNT_W'(1);
				state_d = S_EX_QRD;
			end
			S_EX_QRD: begin
				q_re    = 1'b1;
				q_raddr = head_q[IDX_W-1:0];
				state_d = S_EX_NRD;
			end
			S_EX_NRD: begin
				nd_re    = 1'b1;
				nd_raddr = q_rdata;
				state_d  = S_EX_CH0;
			end
			S_EX_CH0: begin
				rs0_d = '0;
				if (ch0_take) begin
					q_we    = 1'b1;
					q_wdata = nd_rnode.r1[IDX_W-1:0];
					tail_d  = tail_q + CNT_W'(1);
					rs0_d   = tail_q + CNT_W'(1);
				end
				state_d = S_EX_CH1;
			end
			S_EX_CH1: begin
				rs1_d = '0;
				if (ch1_take) begin
					q_we    = 1'b1;
					q_wdata = ent_q.r2;
					tail_d  = tail_q + CNT_W'(1);
					rs1_d   = tail_q + CNT_W'(1);
				end
				state_d = S_EX_EMIT;
			end
			S_EX_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					o_kind   = ent_q.kind;
					o_truth  = ent_q.truth;
					o_pos    = head_pos;
					o_last   = ex_last;
					if (ent_q.kind == KIND_LEAF) begin
						o_rf   = ent_q.r1;
						o_rcnt = 2'd1;
					end else begin
						o_rf   = REL_W'(rs0_q);
						o_rs   = REL_W'(rs1_q);
						o_rcnt = ent_q.cnt;
					end
					head_d  = head_q + CNT_W'(1);
					state_d = ex_last ? S_IDLE : S_EX_QRD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= '0;
			depth_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			node_count_q <= node_count_d;
			depth_q      <= depth_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the accepted item and the operands gathered along the way
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q        <= action_t'(action);
			leaf_truth_q <= leaf_truth;
			rel_q        <= relation_id;
			err_q        <= in_err;
		end
		if (state_q == S_RD_OLD) begin
			newer_q <= st_rdata;
		end
		if (state_q == S_RD_TRUTH) begin
			older_q <= st_rdata;
			tn_q    <= nd_rnode.truth;
		end
		if (state_q == S_EX_CH0) begin
			ent_q <= nd_rnode;
		end
		rs0_q <= rs0_d;
		rs1_q <= rs1_d;
		if (load_out) begin
			status_q <= o_status;
			kind_q   <= o_kind;
			truth_q  <= o_truth;
			pos_q    <= o_pos;
			rf_q     <= o_rf;
			rs_q     <= o_rs;
			rcnt_q   <= o_rcnt;
			last_q   <= o_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign node_kind     = kind_q;
	assign node_truth    = truth_q;
	assign position      = pos_q;
	assign reason_first  = rf_q;
	assign reason_second = rs_q;
	assign reason_count  = rcnt_q;
	assign last          = last_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// every stacked index is a stored node
	a_depth_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= node_count_q)
		else $error("work stack deeper than node store");

	// the node store only grows
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> node_count_q >= $past(node_count_q))
		else $error("node count went down");

	// the explain walk never reads past the queue tail
	a_head_lt_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EX_QRD) |-> (head_q < tail_q))
		else $error("explain queue read past tail");

	// the explain queue never outgrows its memory
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= CNT_W'(NODE_SLOTS))
		else $error("explain queue overflow");

	// an error item is always the only item of its input
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> last_q)
		else $error("error item without last");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the postfix boolean evaluator with reasons
// Drives leaves, ANDs, ORs and explains through the valid/ready input
// channel, predicts every result item from its own copy of the node store
// and work stack, and checks the output channel item by item. Both sides
// idle and stall in short random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfbe_pkg::*;

	// run shape
	localparam int RANDOM_ITEMS = 427;
	localparam int QUIET_ITEMS  = 60;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;
	localparam int PRINT_CAP    = 100;

	// Scoreboard: keeps the evaluator state as the block should see it, and
	// the queue of result items still owed by the block.
	class evaluator_scoreboard;
		typedef struct {
			node_kind_t       kind;
			bit               truth;
			bit [REL_W-1:0]   r1;
			bit [REL_W-1:0]   r2;
			bit [1:0]         cnt;
		} node_rec_t;

		typedef struct packed {
			status_t          status;
			node_kind_t       kind;
			logic             truth;
			logic [POS_W-1:0] pos;
			logic [REL_W-1:0] r1;
			logic [REL_W-1:0] r2;
			logic [1:0]       cnt;
			logic             last;
		} reason_item_t;

		node_rec_t    nodes[NODE_SLOTS];
		int unsigned  work_stack[NODE_SLOTS];
		int unsigned  node_count;
		int unsigned  stack_depth;
		reason_item_t owed_items[$];
		int unsigned  checked;
		int           mismatches;

		function new();
			node_count = 0;
			stack_depth = 0;
			checked = 0;
			mismatches = 0;
		endfunction

		task report(string msg);
			if (mismatches < PRINT_CAP)
				$display("%0t MISMATCH %s", $realtime, msg);
			mismatches++;
		endtask

		function void owe_item(status_t st, node_kind_t kind, bit truth, int unsigned pos,
				bit [REL_W-1:0] r1, bit [REL_W-1:0] r2, bit [1:0] cnt, bit last);
			reason_item_t it;
			it.status = st;
			it.kind = kind;
			it.truth = truth;
			it.pos = pos[POS_W-1:0];
			it.r1 = r1;
			it.r2 = r2;
			it.cnt = cnt;
			it.last = last;
			owed_items = {owed_items, it};
		endfunction

		// Walk the tree below the newest node breadth first, one item per node,
		// children renumbered to their tree positions counted from 1.
		function void explain_newest();
			int unsigned walk[NODE_SLOTS];
			int unsigned head, tail, k, j, child;
			bit [REL_W-1:0] r[2];
			bit [1:0] cnt;
			node_rec_t e;
			bit fin;
			walk[0] = node_count - 1;
			head = 0;
			tail = 1;
			k = 0;
			while (head < tail && k < OUT_LIMIT) begin
				e = nodes[walk[head]];
				r[0] = '0;
				r[1] = '0;
				cnt = e.cnt;
				if (e.kind == KIND_LEAF) begin
					r[0] = e.r1;
					cnt = 1;
				end else begin
					for (j = 0; j < 2 && j < e.cnt; j++) begin
						child = 32'(j ? e.r2 : e.r1);
						if (tail < NODE_SLOTS && child < node_count) begin
							walk[tail] = child;
							tail++;
							r[j] = REL_W'(tail);
						end
					end
				end
				head++;
				k++;
				fin = !(head < tail && k < OUT_LIMIT);
				owe_item(ST_OK, e.kind, e.truth, head, r[0], r[1], cnt, fin);
			end
		endfunction

		// Apply one accepted input item and record the results it owes.
		function void evaluate_action(action_t act, bit truth, bit [REL_W-1:0] rel);
			node_rec_t nn;
			int unsigned newer, older;
			bit tn, to;
			if (act == ACT_EXPLAIN) begin
				if (node_count == 0)
					owe_item(ST_EMPTY, KIND_LEAF, 0, 0, 0, 0, 0, 1);
				else
					explain_newest();
				return;
			end
			// underflow wins over a full store; neither changes any state
			if (act != ACT_LEAF && stack_depth < 2) begin
				owe_item(ST_UNDERFLOW, KIND_LEAF, 0, 0, 0, 0, 0, 1);
				return;
			end
			if (node_count >= NODE_SLOTS) begin
				owe_item(ST_FULL, KIND_LEAF, 0, 0, 0, 0, 0, 1);
				return;
			end
			nn.truth = 0;
			nn.r1 = '0;
			nn.r2 = '0;
			nn.cnt = 0;
			if (act == ACT_LEAF) begin
				nn.kind = KIND_LEAF;
				nn.truth = truth;
				nn.r1 = rel;
				nn.cnt = 1;
			end else begin
				newer = work_stack[stack_depth - 1];
				older = work_stack[stack_depth - 2];
				tn = nodes[newer].truth;
				to = nodes[older].truth;
				stack_depth -= 2;
				if (act == ACT_AND) begin
					nn.kind = KIND_AND;
					nn.truth = tn & to;
					if (nn.truth) begin
						nn.r1 = REL_W'(older);
						nn.r2 = REL_W'(newer);
						nn.cnt = 2;
					end else begin
						// only the false operands decide, older first
						if (!to) begin
							nn.r1 = REL_W'(older);
							nn.cnt = 1;
						end
						if (!tn) begin
							if (nn.cnt != 0) begin
								nn.r2 = REL_W'(newer);
								nn.cnt = 2;
							end else begin
								nn.r1 = REL_W'(newer);
								nn.cnt = 1;
							end
						end
					end
				end else begin
					nn.kind = KIND_OR;
					nn.truth = tn | to;
					if (nn.truth) begin
						if (to) begin
							nn.r1 = REL_W'(older);
							nn.cnt = 1;
						end
						if (tn) begin
							if (nn.cnt != 0) begin
								nn.r2 = REL_W'(newer);
								nn.cnt = 2;
							end else begin
								nn.r1 = REL_W'(newer);
								nn.cnt = 1;
							end
						end
					end else begin
						// a false OR names the newer operand first
						nn.r1 = REL_W'(newer);
						nn.r2 = REL_W'(older);
						nn.cnt = 2;
					end
				end
			end
			nodes[node_count] = nn;
			work_stack[stack_depth] = node_count;
			stack_depth++;
			owe_item(ST_OK, nn.kind, nn.truth, node_count, nn.r1, nn.r2, nn.cnt, 1);
			node_count++;
		endfunction

		task check_result(logic [1:0] st, logic [1:0] kind, logic truth,
				logic [POS_W-1:0] pos, logic [REL_W-1:0] r1, logic [REL_W-1:0] r2,
				logic [1:0] cnt, logic last);
			reason_item_t got, want;
			string bad;
			got.status = status_t'(st);
			got.kind = node_kind_t'(kind);
			got.truth = truth;
			got.pos = pos;
			got.r1 = r1;
			got.r2 = r2;
			got.cnt = cnt;
			got.last = last;
			checked++;
			if (owed_items.size() == 0) begin
				report($sformatf("result %0d arrived with nothing owed: %p", checked, got));
				return;
			end
			want = owed_items.pop_front();
			bad = "";
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.kind !== want.kind) bad = {bad, " node_kind"};
			if (got.truth !== want.truth) bad = {bad, " node_truth"};
			if (got.pos !== want.pos) bad = {bad, " position"};
			if (got.r1 !== want.r1) bad = {bad, " reason_first"};
			if (got.r2 !== want.r2) bad = {bad, " reason_second"};
			if (got.cnt !== want.cnt) bad = {bad, " reason_count"};
			if (got.last !== want.last) bad = {bad, " last"};
			if (bad != "")
				report($sformatf("result %0d differs in%s: got %p want %p",
					checked, bad, got, want));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       action;
	logic             leaf_truth;
	logic [REL_W-1:0] relation_id;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [1:0]       node_kind;
	logic             node_truth;
	logic [POS_W-1:0] position;
	logic [REL_W-1:0] reason_first;
	logic [REL_W-1:0] reason_second;
	logic [1:0]       reason_count;
	logic             last;

	evaluator_scoreboard sb;

	// chance in percent of an idle burst before an item, and of a stall burst
	int unsigned gap_pct;
	int unsigned stall_pct;

	postfix_boolean_evaluator_with_reasons_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.leaf_truth    (leaf_truth),
		.relation_id   (relation_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.node_kind     (node_kind),
		.node_truth    (node_truth),
		.position      (position),
		.reason_first  (reason_first),
		.reason_second (reason_second),
		.reason_count  (reason_count),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Present one item at a falling edge, hold it until a rising edge sees
	// valid and ready together, then hand it to the scoreboard.
	task automatic send_item(action_t act, logic truth, logic [REL_W-1:0] rel);
		int unsigned gap;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(3, 1);
			repeat (gap) @(negedge clk) in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		leaf_truth <= truth;
		relation_id <= rel;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.evaluate_action(act, truth, rel);
	endtask

	// Non-leaf actions carry random, ignored leaf fields.
	task automatic send_op(action_t act);
		send_item(act, 1'($urandom_range(1)), REL_W'($urandom_range(16'hFFFF)));
	endtask

	// Directed opening: empty explain, underflow on AND and OR, relation id
	// extremes, every AND and OR outcome with its deciding operands, explains.
	task automatic run_directed();
		send_op(ACT_EXPLAIN);                // nothing stored yet
		send_op(ACT_AND);                    // empty stack
		send_item(ACT_LEAF, 1, 16'hFFFF);    // node 0
		send_op(ACT_OR);                     // only one index stacked
		send_item(ACT_LEAF, 1, 16'h0000);    // node 1
		send_op(ACT_AND);                    // true AND: both operands
		send_item(ACT_LEAF, 0, 16'h8000);
		send_op(ACT_AND);                    // false AND, newer operand false
		send_item(ACT_LEAF, 0, 16'h0001);
		send_op(ACT_AND);                    // false AND, both false
		send_item(ACT_LEAF, 1, 16'h5555);
		send_op(ACT_OR);                     // true OR, newer true
		send_item(ACT_LEAF, 0, 16'hAAAA);
		send_op(ACT_OR);                     // true OR, older true
		send_item(ACT_LEAF, 1, 16'h1234);
		send_op(ACT_OR);                     // true OR, both true
		send_item(ACT_LEAF, 0, 16'h7FFF);
		send_item(ACT_LEAF, 0, 16'hFFFE);
		send_op(ACT_OR);                     // false OR: newer first
		send_op(ACT_AND);                    // false AND, older true newer false
		send_op(ACT_EXPLAIN);
		send_item(ACT_LEAF, 1, 16'h00FF);
		send_op(ACT_AND);                    // false AND, older false newer true
		send_op(ACT_EXPLAIN);
	endtask

	// Random part. Reset is applied once, so the store fills for good: first
	// grow it with mostly well-formed postfix content (some underflows and
	// explains), leaning on combines toward the end so the final trees are
	// deep, then hammer explains and the error paths of a full store.
	task automatic run_random();
		int unsigned n, roll;
		action_t act;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (n % 16 == 0) begin
				gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
				stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
			end
			roll = $urandom_range(99);
			if (sb.node_count < NODE_SLOTS) begin
				if (sb.stack_depth < 2)
					act = (roll < 88) ? ACT_LEAF : ((roll < 94) ? ACT_AND : ACT_OR);
				else if (roll < 10)
					act = ACT_EXPLAIN;
				else if (sb.node_count > 20)
					act = (roll < 28) ? ACT_LEAF : ((roll < 64) ? ACT_AND : ACT_OR);
				else
					act = (roll < 50) ? ACT_LEAF : ((roll < 75) ? ACT_AND : ACT_OR);
			end else begin
				act = (roll < 55) ? ACT_EXPLAIN : action_t'($urandom_range(2));
			end
			send_item(act, 1'($urandom_range(1)), REL_W'($urandom_range(16'hFFFF)));
		end
	endtask

	// Receiver: stall in random bursts, decided at falling edges.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(3, 1) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check every accepted result against the oldest owed item.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(status, node_kind, node_truth, position, reason_first,
				reason_second, reason_count, last);
	end

	// Watchdog: end the run when neither channel moves an item for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1) ||
					(out_valid === 1'b1 && out_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end while (quiet < QUIET_LIMIT);
		$display("%0t timeout: no item moved for %0d cycles", $realtime, QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		sb = new();
		gap_pct = 30;
		stall_pct = 30;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_LEAF;
		leaf_truth = 1'b0;
		relation_id = '0;
		// hold reset, then release it away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		run_directed();
		run_random();
		@(negedge clk) in_valid <= 1'b0;

		// drain every owed result, then give stray items time to show up
		while (sb.owed_items.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
